@@ hw/rtl/pidaw_pkg.sv @@
// pidaw_pkg: shared types and constants for the pid controller with anti-windup
// used by pidaw_mul, pidaw_div and pid_controller_antiwindup; no dependencies
package pidaw_pkg;

   localparam int unsigned IO_WIDTH        = 32;
   localparam int unsigned GAIN_WIDTH      = 32;
   localparam int unsigned BOUND_WIDTH     = 31;
   localparam int unsigned DT_WIDTH        = 16;
   localparam int unsigned DT_FRAC         = 16;
   localparam int unsigned REQ_DATA_WIDTH  = 80;
   localparam int unsigned RSP_USER_WIDTH  = 2;
   localparam int unsigned MUL_STEPS       = 32;
   localparam int unsigned MUL_CNT_WIDTH   = 5;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEGRAL_BOUND = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_BOUND   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_DIV,
      ST_EDT,
      ST_CAND,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_CLAMP,
      ST_FINISH
   } state_type;

   // handshake of a serial arithmetic unit back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

@@ hw/rtl/pidaw_mul.sv @@
// pidaw_mul: bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on pidaw_pkg
module pidaw_mul #(
   parameter int unsigned MCAND_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [MCAND_WIDTH-1:0]                        mcand,
   input  logic [pidaw_pkg::MUL_STEPS-1:0]               mplier,
   output logic [MCAND_WIDTH+pidaw_pkg::MUL_STEPS-1:0]   product,
   output pidaw_pkg::unit_status_type                    status
);

   logic                                 busy_ff;
   logic                                 done_ff;
   logic [pidaw_pkg::MUL_CNT_WIDTH-1:0]  cnt_ff;
   logic [MCAND_WIDTH-1:0]               mcand_ff;
   logic [MCAND_WIDTH-1:0]               hi_ff;
   logic [pidaw_pkg::MUL_STEPS-1:0]      lo_ff;
   logic [MCAND_WIDTH:0]                 sum_in;

   // add the multiplicand when the low bit of the multiplier is set
   always_comb begin
      sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + pidaw_pkg::MUL_CNT_WIDTH'(1);
            if (cnt_ff == pidaw_pkg::MUL_CNT_WIDTH'(pidaw_pkg::MUL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         hi_ff    <= '0;
         lo_ff    <= mplier;
      end else if (busy_ff) begin
         hi_ff <= sum_in[MCAND_WIDTH:1];
         lo_ff <= {sum_in[0], lo_ff[pidaw_pkg::MUL_STEPS-1:1]};
      end
   end

   assign product = {hi_ff, lo_ff};
   assign status  = '{busy: busy_ff, done: done_ff};

endmodule

@@ hw/rtl/pidaw_div.sv @@
// pidaw_div: restoring bit-serial divider by the time step, one quotient bit per cycle
// depends on pidaw_pkg
module pidaw_div #(
   parameter int unsigned NUM_WIDTH = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [NUM_WIDTH-1:0]             dividend,
   input  logic [pidaw_pkg::DT_WIDTH-1:0]   divisor,
   output logic [NUM_WIDTH-1:0]             quotient,
   output pidaw_pkg::unit_status_type       status
);

   localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH);

   logic                             busy_ff;
   logic                             done_ff;
   logic [CNT_WIDTH-1:0]             cnt_ff;
   logic [pidaw_pkg::DT_WIDTH-1:0]   div_ff;
   logic [pidaw_pkg::DT_WIDTH-1:0]   rem_ff;
   logic [NUM_WIDTH-1:0]             quo_ff;
   logic [pidaw_pkg::DT_WIDTH:0]     shifted;
   logic [pidaw_pkg::DT_WIDTH:0]     trial;
   logic                             qbit;
   logic [pidaw_pkg::DT_WIDTH-1:0]   rem_in;

   // dividend bits leave from the top of the quotient register as quotient bits enter at the bottom
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_WIDTH-1]};
      trial   = shifted - {1'b0, div_ff};
      qbit    = (shifted >= {1'b0, div_ff});
      rem_in  = qbit ? trial[pidaw_pkg::DT_WIDTH-1:0] : shifted[pidaw_pkg::DT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_WIDTH'(NUM_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NUM_WIDTH-2:0], qbit};
      end
   end

   assign quotient = quo_ff;
   assign status   = '{busy: busy_ff, done: done_ff};

endmodule

@@ hw/rtl/pid_controller_antiwindup.sv @@
// pid_controller_antiwindup: fixed-point pid controller with conditional integration
// depends on pidaw_pkg, pidaw_mul and pidaw_div
//
//   port group   direction  transfer payload
//   req_*        in         error_in, feedforward_in, time_step
//   rsp_*        out        drive_out; tuser clamped, rejected
//   csr_*        in         gain_p, gain_i, gain_d, integral_bound, output_bound
//
// one sample at a time; a sample with a zero time_step is rejected without arithmetic
// the divider runs only once primed, since the first sample has no last error
// each other sample runs four 32-step serial multiplies after the serial divider (DATA_WIDTH + 16 steps)
// reset is synchronous; it clears the integrator, the last error and the configuration registers
// a finished result waits in the output register; the next sample is taken meanwhile
module pid_controller_antiwindup #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // error_in [31:0], feedforward_in [63:32], time_step [79:64]
   input  logic [pidaw_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // drive_out [31:0]
   output logic [pidaw_pkg::IO_WIDTH-1:0]         rsp_tdata,
   // clamped [0], rejected [1]
   output logic [pidaw_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser,
   input  logic                                   csr_we,
   input  logic [pidaw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pidaw_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int unsigned DW = DATA_WIDTH;
   localparam int unsigned PW = DW + pidaw_pkg::MUL_STEPS;
   localparam int unsigned NW = DW + pidaw_pkg::DT_FRAC;
   localparam int unsigned CW = ((DW > pidaw_pkg::IO_WIDTH) ? DW : pidaw_pkg::IO_WIDTH) + 1;

   localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [PW-1:0] MAG_MAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic [PW-1:0] MAG_MIN = {{(PW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

   // ---------------------------------------------------------------- helpers

   function automatic logic signed [DW-1:0] sat_in(input logic signed [pidaw_pkg::IO_WIDTH-1:0] x);
      logic signed [CW-1:0] xx;
      xx = CW'(x);
      if (xx > CW'(S_MAX)) sat_in = S_MAX;
      else if (xx < CW'(S_MIN)) sat_in = S_MIN;
      else sat_in = xx[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = (DW+1)'(a) + (DW+1)'(b);
      if (s[DW] != s[DW-1]) sat_add = s[DW] ? S_MIN : S_MAX;
      else sat_add = s[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = (DW+1)'(a) - (DW+1)'(b);
      if (s[DW] != s[DW-1]) sat_sub = s[DW] ? S_MIN : S_MAX;
      else sat_sub = s[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] u);
      mag_of = u[DW-1] ? DW'(0) - u : u;
   endfunction

   function automatic logic [pidaw_pkg::GAIN_WIDTH-1:0] gain_mag(
      input logic [pidaw_pkg::GAIN_WIDTH-1:0] g);
      gain_mag = g[pidaw_pkg::GAIN_WIDTH-1] ? pidaw_pkg::GAIN_WIDTH'(0) - g : g;
   endfunction

   // apply a sign to a magnitude, saturating to the data range
   function automatic logic signed [DW-1:0] sat_mag(input logic neg, input logic [PW-1:0] m);
      logic [DW-1:0] low;
      low = m[DW-1:0];
      if (neg) begin
         if (m > MAG_MIN) sat_mag = S_MIN;
         else sat_mag = DW'(0) - low;
      end else begin
         if (m > MAG_MAX) sat_mag = S_MAX;
         else sat_mag = low;
      end
   endfunction

   function automatic logic signed [DW-1:0] clamp_to(input logic signed [DW-1:0] v,
                                                     input logic [pidaw_pkg::BOUND_WIDTH-1:0] lim);
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] lx;
      logic signed [CW-1:0] nx;
      vx = CW'(v);
      lx = CW'(lim);
      nx = -lx;
      if (vx > lx) clamp_to = lx[DW-1:0];
      else if (vx < nx) clamp_to = nx[DW-1:0];
      else clamp_to = v;
   endfunction

   // ---------------------------------------------------------------- state

   pidaw_pkg::state_type state_ff, state_in;

   logic signed [DW-1:0]                    err_ff;
   logic signed [DW-1:0]                    ffw_ff;
   logic [pidaw_pkg::DT_WIDTH-1:0]          dt_ff;
   logic                                    rej_ff;
   logic                                    dneg_ff;
   logic signed [DW-1:0]                    deriv_ff;
   logic signed [DW-1:0]                    edt_ff;
   logic signed [DW-1:0]                    cand_ff;
   logic signed [DW-1:0]                    sum_ff;
   logic signed [DW-1:0]                    outv_ff;
   logic                                    clip_ff;
   logic                                    mneg_ff;

   logic signed [DW-1:0]                    acc_ff;
   logic signed [DW-1:0]                    last_ff;
   logic                                    primed_ff;

   logic [pidaw_pkg::GAIN_WIDTH-1:0]        gain_p_ff;
   logic [pidaw_pkg::GAIN_WIDTH-1:0]        gain_i_ff;
   logic [pidaw_pkg::GAIN_WIDTH-1:0]        gain_d_ff;
   logic [pidaw_pkg::BOUND_WIDTH-1:0]       ibound_ff;
   logic [pidaw_pkg::BOUND_WIDTH-1:0]       obound_ff;

   logic                                    rsp_valid_ff;
   logic [pidaw_pkg::IO_WIDTH-1:0]          rsp_drive_ff;
   logic                                    rsp_clamped_ff;
   logic                                    rsp_rejected_ff;

   logic                                    accept;
   logic                                    rsp_load;
   logic                                    mul_start;
   logic                                    div_start;
   logic [DW-1:0]                           mul_mcand;
   logic [pidaw_pkg::MUL_STEPS-1:0]         mul_mplier;
   logic                                    mul_neg;
   logic [PW-1:0]                           mul_prod;
   logic [NW-1:0]                           div_quo;
   pidaw_pkg::unit_status_type              mul_st;
   pidaw_pkg::unit_status_type              div_st;
   logic signed [DW-1:0]                    diff;
   logic signed [DW-1:0]                    term;
   logic signed [DW-1:0]                    edt_val;
   logic signed [DW-1:0]                    outv;
   logic                                    clip_now;
   logic                                    take_cand;
   logic signed [CW-1:0]                    drive_ext;

   // ---------------------------------------------------------------- serial units

   pidaw_mul #(
      .MCAND_WIDTH (DW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .product (mul_prod),
      .status  (mul_st)
   );

   pidaw_div #(
      .NUM_WIDTH (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({mag_of(diff), {pidaw_pkg::DT_FRAC{1'b0}}}),
      .divisor  (dt_ff),
      .quotient (div_quo),
      .status   (div_st)
   );

   // ---------------------------------------------------------------- sequencer

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidaw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mul_start  = 1'b0;
      div_start  = 1'b0;
      mul_mcand  = mag_of(err_ff);
      mul_mplier = pidaw_pkg::MUL_STEPS'(dt_ff);
      mul_neg    = err_ff[DW-1];
      diff       = sat_sub(err_ff, last_ff);
      term       = sat_mag(mneg_ff, mul_prod >> FRAC_BITS);
      edt_val    = sat_mag(mneg_ff, mul_prod >> pidaw_pkg::DT_FRAC);
      outv       = clamp_to(sum_ff, obound_ff);
      clip_now   = (outv != sum_ff);
      take_cand  = !clip_now
                   || (!outv[DW-1] && outv != '0 && err_ff[DW-1])
                   || (outv[DW-1] && !err_ff[DW-1] && err_ff != '0);
      case (state_ff)
         pidaw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tdata[79:64] == '0) ? pidaw_pkg::ST_FINISH : pidaw_pkg::ST_DIFF;
            end
         end
         pidaw_pkg::ST_DIFF: begin
            if (primed_ff) begin
               div_start = 1'b1;
               state_in  = pidaw_pkg::ST_DIV;
            end else begin
               mul_start = 1'b1;
               state_in  = pidaw_pkg::ST_EDT;
            end
         end
         pidaw_pkg::ST_DIV: begin
            if (div_st.done) begin
               mul_start = 1'b1;
               state_in  = pidaw_pkg::ST_EDT;
            end
         end
         pidaw_pkg::ST_EDT: begin
            if (mul_st.done) state_in = pidaw_pkg::ST_CAND;
         end
         pidaw_pkg::ST_CAND: begin
            mul_start  = 1'b1;
            mul_mplier = gain_mag(gain_p_ff);
            mul_neg    = err_ff[DW-1] ^ gain_p_ff[pidaw_pkg::GAIN_WIDTH-1];
            state_in   = pidaw_pkg::ST_MUL_P;
         end
         pidaw_pkg::ST_MUL_P: begin
            mul_mcand  = mag_of(cand_ff);
            mul_mplier = gain_mag(gain_i_ff);
            mul_neg    = cand_ff[DW-1] ^ gain_i_ff[pidaw_pkg::GAIN_WIDTH-1];
            if (mul_st.done) begin
               mul_start = 1'b1;
               state_in  = pidaw_pkg::ST_MUL_I;
            end
         end
         pidaw_pkg::ST_MUL_I: begin
            mul_mcand  = mag_of(deriv_ff);
            mul_mplier = gain_mag(gain_d_ff);
            mul_neg    = deriv_ff[DW-1] ^ gain_d_ff[pidaw_pkg::GAIN_WIDTH-1];
            if (mul_st.done) begin
               mul_start = 1'b1;
               state_in  = pidaw_pkg::ST_MUL_D;
            end
         end
         pidaw_pkg::ST_MUL_D: begin
            if (mul_st.done) state_in = pidaw_pkg::ST_CLAMP;
         end
         pidaw_pkg::ST_CLAMP: begin
            state_in = pidaw_pkg::ST_FINISH;
         end
         pidaw_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) state_in = pidaw_pkg::ST_IDLE;
         end
         default: begin
            state_in = pidaw_pkg::ST_IDLE;
         end
      endcase
   end

   assign accept   = req_tvalid && req_tready;
   assign rsp_load = (state_ff == pidaw_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // ---------------------------------------------------------------- datapath

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff <= sat_in(req_tdata[31:0]);
         ffw_ff <= sat_in(req_tdata[63:32]);
         dt_ff  <= req_tdata[79:64];
         rej_ff <= (req_tdata[79:64] == '0);
      end
      if (mul_start) mneg_ff <= mul_neg;
      case (state_ff)
         pidaw_pkg::ST_DIFF: begin
            dneg_ff  <= diff[DW-1];
            deriv_ff <= '0;
         end
         pidaw_pkg::ST_DIV: begin
            if (div_st.done) deriv_ff <= sat_mag(dneg_ff, PW'(div_quo));
         end
         pidaw_pkg::ST_EDT: begin
            if (mul_st.done) edt_ff <= edt_val;
         end
         pidaw_pkg::ST_CAND: begin
            cand_ff <= clamp_to(sat_add(acc_ff, edt_ff), ibound_ff);
         end
         pidaw_pkg::ST_MUL_P: begin
            if (mul_st.done) sum_ff <= sat_add(ffw_ff, term);
         end
         pidaw_pkg::ST_MUL_I, pidaw_pkg::ST_MUL_D: begin
            if (mul_st.done) sum_ff <= sat_add(sum_ff, term);
         end
         pidaw_pkg::ST_CLAMP: begin
            outv_ff <= outv;
            clip_ff <= clip_now;
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_drive_ff    <= rej_ff ? '0 : drive_ext[pidaw_pkg::IO_WIDTH-1:0];
         rsp_clamped_ff  <= !rej_ff && clip_ff;
         rsp_rejected_ff <= rej_ff;
      end
   end

   assign drive_ext = CW'(outv_ff);

   // controller state, configuration and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         last_ff      <= '0;
         primed_ff    <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         ibound_ff    <= '0;
         obound_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == pidaw_pkg::ST_CLAMP) begin
            if (take_cand) acc_ff <= cand_ff;
            last_ff   <= err_ff;
            primed_ff <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               pidaw_pkg::CSR_GAIN_P:         gain_p_ff <= csr_wdata;
               pidaw_pkg::CSR_GAIN_I:         gain_i_ff <= csr_wdata;
               pidaw_pkg::CSR_GAIN_D:         gain_d_ff <= csr_wdata;
               pidaw_pkg::CSR_INTEGRAL_BOUND: ibound_ff <= csr_wdata[pidaw_pkg::BOUND_WIDTH-1:0];
               pidaw_pkg::CSR_OUTPUT_BOUND:   obound_ff <= csr_wdata[pidaw_pkg::BOUND_WIDTH-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign req_tready = (state_ff == pidaw_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = {rsp_rejected_ff, rsp_clamped_ff};

`ifndef SYNTHESIS
   // the sequencer never runs the divider and the multiplier together
   assert property (@(posedge clock) disable iff (reset) !(mul_st.busy && div_st.busy))
      else $error("multiplier and divider busy at once");

   // no serial unit may still be running when a new sample can be taken
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == pidaw_pkg::ST_IDLE) |-> (!mul_st.busy && !div_st.busy))
      else $error("serial unit busy while idle");

   // once primed, only reset clears the first-sample flag
   assert property (@(posedge clock) disable iff (reset) $fell(primed_ff) |-> $past(reset))
      else $error("primed flag dropped without reset");
`endif

endmodule
